// ----- design/pals_pkg.sv -----
// Shared types and constants for the polyline arc-length sampler.
`timescale 1ns / 1ps
`default_nettype none
package pals_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned FRAC_BITS_DEF    = 8;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned SQ_W    = 34;                // dx*dx + dy*dy
  localparam int unsigned SQ_INT  = SQ_W / 2;          // integer root bits
  localparam int unsigned NUM_W   = 50;                // 2*t*ds + d
  localparam int unsigned DEN_W   = 33;                // 2*d
  localparam int unsigned QUO_W   = 18;                // quotient bits
  localparam logic [LEN_W-1:0] LEN_MAX = 32'h7FFF_FFFF;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_START,
    ST_A_SQX,
    ST_A_SQY,
    ST_A_SQRT,
    ST_A_WAIT,
    ST_A_WR,
    ST_Q_START,
    ST_Q_CHK,
    ST_S_RD,
    ST_S_CMP,
    ST_L_RDA,
    ST_L_RDB,
    ST_L_CAPB,
    ST_M_MUL,
    ST_M_NUM,
    ST_M_GO,
    ST_M_WAIT,
    ST_Q_OUT
  } pals_state_e;

endpackage
`default_nettype wire

// ----- design/polyline_arc_length_sampler.sv -----
// Polyline arc-length sampler: vertex store, length search and interpolation.
// Append: the time per item is set by the bit-serial root; the first vertex of a
// path is written at length zero without a root.
// Query: an empty path and distances at the ends need no search; inside the path
// the query runs a binary search (at most ceil(log2(vertex count - 1)) steps) and
// two 18-step serial divisions. One item is in work at a time; a result waits in
// the output register. Reset empties the polyline; store contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module polyline_arc_length_sampler #(
  parameter int unsigned MAX_VERTICES = pals_pkg::MAX_VERTICES_DEF,
  parameter int unsigned FRAC_BITS    = pals_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               func_i,
  input  wire logic               new_path_i,
  input  wire logic signed [15:0] vx_i,
  input  wire logic signed [15:0] vy_i,
  input  wire logic signed [31:0] query_dist_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      px_o,
  output logic signed [15:0]      py_o
);
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned RW = pals_pkg::SQ_INT + FRAC_BITS;
  localparam int unsigned LW = pals_pkg::LEN_W;
  localparam int unsigned XW = pals_pkg::COORD_W;
  localparam int unsigned NW = pals_pkg::NUM_W;
  localparam int unsigned QW = pals_pkg::QUO_W;

  // vertex and cumulative length stores
  logic [XW-1:0] mem_x_q [MAX_VERTICES];
  logic [XW-1:0] mem_y_q [MAX_VERTICES];
  logic [LW-1:0] mem_len_q [MAX_VERTICES];
  logic [XW-1:0] rd_x_q, rd_y_q;
  logic [LW-1:0] rd_len_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [XW-1:0] wr_x, wr_y;
  logic [LW-1:0] wr_len;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x_q[wr_addr]   <= wr_x;
      mem_y_q[wr_addr]   <= wr_y;
      mem_len_q[wr_addr] <= wr_len;
    end
    rd_x_q   <= mem_x_q[rd_addr];
    rd_y_q   <= mem_y_q[rd_addr];
    rd_len_q <= mem_len_q[rd_addr];
  end

  // control state
  pals_pkg::pals_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  logic [XW-1:0] vx_q, vx_d, vy_q, vy_d, lx_q, lx_d, ly_q, ly_d;
  logic [LW-1:0] s_q, s_d, llen_q, llen_d;
  logic [pals_pkg::SQ_W-1:0] sq_q, sq_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [XW-1:0] xa_q, xa_d, ya_q, ya_d, xb_q, xb_d, yb_q, yb_d;
  logic [LW-1:0] la_q, la_d, lb_q, lb_d;
  logic          sel_y_q, sel_y_d, neg_q, neg_d;
  logic signed [NW-1:0] prod_q, prod_d;
  logic [NW-1:0] n_q, n_d;
  logic [XW-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
  logic [XW-1:0] px_q, px_d, py_q, py_d;

  // shared arithmetic
  logic           sqrt_start, sqrt_done, div_start, div_done;
  logic [RW-1:0]  root;
  logic [QW-1:0]  quo;
  logic           rem_nz;
  logic [CW-1:0]  count_m1;
  logic [AW-1:0]  last_w, mid, mid_p1;
  logic [AW:0]    mid_sum;
  logic           s_le0;
  logic signed [XW:0] dx, dy, t;
  logic signed [2*XW+1:0] sqx, sqy;
  logic [LW-1:0]  ds, dd;
  logic [NW-1:0]  mag;
  logic [pals_pkg::SQ_W-1:0] total;
  logic [LW-1:0]  total_sat;
  logic [QW:0]    qs;
  logic [XW-1:0]  coord_a, lerp_res;

  pals_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .sq_i    (sq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  pals_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (mag),
    .den_i    ({dd, 1'b0}),
    .done_o   (div_done),
    .quo_o    (quo),
    .rem_nz_o (rem_nz)
  );

  always_comb begin
    count_m1  = count_q - CW'(1);
    last_w    = count_m1[AW-1:0];
    mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
    mid       = mid_sum[AW:1];
    mid_p1    = mid + AW'(1);
    s_le0     = s_q[LW-1] || (s_q == '0);
    dx        = $signed({vx_q[XW-1], vx_q}) - $signed({rd_x_q[XW-1], rd_x_q});
    dy        = $signed({vy_q[XW-1], vy_q}) - $signed({ly_q[XW-1], ly_q});
    sqx       = dx * dx;
    sqy       = dy * dy;
    t         = sel_y_q ? ($signed({yb_q[XW-1], yb_q}) - $signed({ya_q[XW-1], ya_q}))
                        : ($signed({xb_q[XW-1], xb_q}) - $signed({xa_q[XW-1], xa_q}));
    ds        = s_q - la_q;
    dd        = lb_q - la_q;
    mag       = n_q[NW-1] ? (~n_q + NW'(1)) : n_q;
    // sum of stored length and new segment, saturated at the length limit
    total     = {2'b00, llen_q} + pals_pkg::SQ_W'(root);
    total_sat = (total > pals_pkg::SQ_W'(pals_pkg::LEN_MAX)) ? pals_pkg::LEN_MAX
                                                             : total[LW-1:0];
    // floor quotient: negate and round down on a negative numerator
    qs        = neg_q ? (~({1'b0, quo} + (QW+1)'(rem_nz)) + (QW+1)'(1)) : {1'b0, quo};
    coord_a   = sel_y_q ? ya_q : xa_q;
    lerp_res  = coord_a + qs[XW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    vx_d = vx_q;  vy_d = vy_q;  lx_d = lx_q;  ly_d = ly_q;
    s_d = s_q;    llen_d = llen_q;  sq_d = sq_q;
    lo_d = lo_q;  hi_d = hi_q;
    xa_d = xa_q;  ya_d = ya_q;  xb_d = xb_q;  yb_d = yb_q;
    la_d = la_q;  lb_d = lb_q;
    sel_y_d = sel_y_q;  neg_d = neg_q;
    prod_d = prod_q;  n_d = n_q;
    res_x_d = res_x_q;  res_y_d = res_y_q;
    px_d = px_q;  py_d = py_q;
    rd_addr = last_w;
    wr_en   = 1'b0;
    wr_addr = last_w;
    wr_x    = vx_q;
    wr_y    = vy_q;
    wr_len  = llen_q;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    in_stall_o = (state_q != pals_pkg::ST_IDLE);

    // drop the result once the consumer takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pals_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          vx_d = vx_i;
          vy_d = vy_i;
          s_d  = query_dist_i;
          if (func_i) begin
            state_d = pals_pkg::ST_Q_START;
          end else begin
            if (new_path_i) begin
              count_d = '0;
            end
            state_d = pals_pkg::ST_A_START;
          end
        end
      end
      pals_pkg::ST_A_START: begin
        if (count_q == '0) begin
          // first vertex of a path sits at length zero
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_len  = '0;
          count_d = CW'(1);
          state_d = pals_pkg::ST_IDLE;
        end else begin
          state_d = pals_pkg::ST_A_SQX;
        end
      end
      pals_pkg::ST_A_SQX: begin
        lx_d   = rd_x_q;
        ly_d   = rd_y_q;
        llen_d = rd_len_q;
        sq_d   = sqx[pals_pkg::SQ_W-1:0];
        state_d = pals_pkg::ST_A_SQY;
      end
      pals_pkg::ST_A_SQY: begin
        sq_d    = sq_q + sqy[pals_pkg::SQ_W-1:0];
        state_d = pals_pkg::ST_A_SQRT;
      end
      pals_pkg::ST_A_SQRT: begin
        sqrt_start = 1'b1;
        state_d = pals_pkg::ST_A_WAIT;
      end
      pals_pkg::ST_A_WAIT: begin
        if (sqrt_done) begin
          state_d = pals_pkg::ST_A_WR;
        end
      end
      pals_pkg::ST_A_WR: begin
        if (total_sat == llen_q) begin
          // zero-length step: replace the last vertex
          wr_en = 1'b1;
        end else if (count_q != CW'(MAX_VERTICES)) begin
          wr_en   = 1'b1;
          wr_addr = count_q[AW-1:0];
          wr_len  = total_sat;
          count_d = count_q + CW'(1);
        end
        state_d = pals_pkg::ST_IDLE;
      end
      pals_pkg::ST_Q_START: begin
        if (count_q == '0) begin
          res_x_d = '0;
          res_y_d = '0;
          state_d = pals_pkg::ST_Q_OUT;
        end else begin
          rd_addr = s_le0 ? '0 : last_w;
          state_d = pals_pkg::ST_Q_CHK;
        end
      end
      pals_pkg::ST_Q_CHK: begin
        if (s_le0 || (s_q >= rd_len_q)) begin
          res_x_d = rd_x_q;
          res_y_d = rd_y_q;
          state_d = pals_pkg::ST_Q_OUT;
        end else begin
          lo_d = AW'(1);
          hi_d = last_w;
          state_d = (last_w == AW'(1)) ? pals_pkg::ST_L_RDA : pals_pkg::ST_S_RD;
        end
      end
      pals_pkg::ST_S_RD: begin
        rd_addr = mid;
        state_d = pals_pkg::ST_S_CMP;
      end
      pals_pkg::ST_S_CMP: begin
        // narrow toward the first vertex whose length is beyond the distance
        if (rd_len_q > s_q) begin
          hi_d    = mid;
          state_d = (lo_q == mid) ? pals_pkg::ST_L_RDA : pals_pkg::ST_S_RD;
        end else begin
          lo_d    = mid_p1;
          state_d = (mid_p1 == hi_q) ? pals_pkg::ST_L_RDA : pals_pkg::ST_S_RD;
        end
      end
      pals_pkg::ST_L_RDA: begin
        rd_addr = lo_q - AW'(1);
        state_d = pals_pkg::ST_L_RDB;
      end
      pals_pkg::ST_L_RDB: begin
        rd_addr = lo_q;
        xa_d = rd_x_q;
        ya_d = rd_y_q;
        la_d = rd_len_q;
        state_d = pals_pkg::ST_L_CAPB;
      end
      pals_pkg::ST_L_CAPB: begin
        xb_d = rd_x_q;
        yb_d = rd_y_q;
        lb_d = rd_len_q;
        sel_y_d = 1'b0;
        state_d = pals_pkg::ST_M_MUL;
      end
      pals_pkg::ST_M_MUL: begin
        prod_d  = t * $signed({1'b0, ds});
        state_d = pals_pkg::ST_M_NUM;
      end
      pals_pkg::ST_M_NUM: begin
        n_d     = {prod_q[NW-2:0], 1'b0} + NW'(dd);
        state_d = pals_pkg::ST_M_GO;
      end
      pals_pkg::ST_M_GO: begin
        neg_d = n_q[NW-1];
        div_start = 1'b1;
        state_d = pals_pkg::ST_M_WAIT;
      end
      pals_pkg::ST_M_WAIT: begin
        if (div_done) begin
          if (sel_y_q) begin
            res_y_d = lerp_res;
            state_d = pals_pkg::ST_Q_OUT;
          end else begin
            res_x_d = lerp_res;
            sel_y_d = 1'b1;
            state_d = pals_pkg::ST_M_MUL;
          end
        end
      end
      pals_pkg::ST_Q_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          px_d = res_x_q;
          py_d = res_y_q;
          state_d = pals_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pals_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pals_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q <= vx_d;  vy_q <= vy_d;  lx_q <= lx_d;  ly_q <= ly_d;
    s_q <= s_d;    llen_q <= llen_d;  sq_q <= sq_d;
    lo_q <= lo_d;  hi_q <= hi_d;
    xa_q <= xa_d;  ya_q <= ya_d;  xb_q <= xb_d;  yb_q <= yb_d;
    la_q <= la_d;  lb_q <= lb_d;
    sel_y_q <= sel_y_d;  neg_q <= neg_d;
    prod_q <= prod_d;  n_q <= n_d;
    res_x_q <= res_x_d;  res_y_q <= res_y_d;
    px_q <= px_d;  py_q <= py_d;
  end

  assign out_valid_o = out_valid_q;
  assign px_o        = px_q;
  assign py_o        = py_q;
endmodule
`default_nettype wire

// ----- design/pals_sqrt.sv -----
// Bit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pals_sqrt #(
  parameter int unsigned FRAC_BITS = pals_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [pals_pkg::SQ_W-1:0]       sq_i,
  output logic                                 done_o,
  output logic [pals_pkg::SQ_INT+FRAC_BITS-1:0] root_o
);
  localparam int unsigned RW = pals_pkg::SQ_INT + FRAC_BITS;
  localparam int unsigned CW = $clog2(RW + 1);

  logic [pals_pkg::SQ_W-1:0] sq_q;
  logic [RW+1:0]             rem_q, rem_sh, trial;
  logic [RW-1:0]             root_q;
  logic [CW-1:0]             cnt_q;
  logic                      busy_q, done_q, ge;

  always_comb begin
    rem_sh = {rem_q[RW-1:0], sq_q[pals_pkg::SQ_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sq_q   <= sq_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      sq_q   <= {sq_q[pals_pkg::SQ_W-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

// ----- design/pals_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pals_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [pals_pkg::NUM_W-1:0]   num_i,
  input  wire logic [pals_pkg::DEN_W-1:0]   den_i,
  output logic                              done_o,
  output logic [pals_pkg::QUO_W-1:0]        quo_o,
  output logic                              rem_nz_o
);
  localparam int unsigned QW = pals_pkg::QUO_W;
  localparam int unsigned RMW = pals_pkg::DEN_W + 1;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [RMW-1:0]              rem_q, rem_sh;
  logic [pals_pkg::DEN_W-1:0]  den_q;
  logic [QW-1:0]               lo_q;
  logic [CW-1:0]               cnt_q;
  logic                        busy_q, done_q, ge;

  always_comb begin
    rem_sh = {rem_q[RMW-2:0], lo_q[QW-1]};
    ge     = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RMW'(num_i[pals_pkg::NUM_W-1:QW]);
      lo_q  <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      lo_q  <= {lo_q[QW-2:0], ge};
    end
  end

  assign done_o   = done_q;
  assign quo_o    = lo_q;
  assign rem_nz_o = (rem_q != '0);
endmodule
`default_nettype wire
